// ----- design/legendre_series_evaluator_assert.svh -----
// assertion macros shared by the legendre series evaluator checks
`ifndef LEGENDRE_SERIES_EVALUATOR_ASSERT_SVH
`define LEGENDRE_SERIES_EVALUATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LSE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define LSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/lse_pkg.sv -----
// types, constants and microprogram for the legendre series evaluator
`default_nettype none

package lse_pkg;

	localparam int X_W    = 18;  // point, Q2.16
	localparam int COEF_W = 32;  // coefficient and result, Q16.16
	localparam int P_W    = 32;  // polynomial value, Q2.30
	localparam int ORD_W  = 6;
	localparam int IDX_W  = 6;

	localparam logic signed [P_W-1:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [X_W-1:0] X_POS   = 18'sh1_0000;
	localparam logic signed [X_W-1:0] X_NEG   = 18'sh3_0000;

	// reciprocals floor(2^32/d)+1, exact for quotients of values below 2^25
	localparam logic [63:0] RCP_NUM = 64'h1_0000_0000;
	localparam logic [63:0] RCP_TBL [64] = '{
		64'd0, 64'd0, RCP_NUM / 64'd2 + 64'd1, RCP_NUM / 64'd3 + 64'd1,
		RCP_NUM / 64'd4 + 64'd1, RCP_NUM / 64'd5 + 64'd1,
		RCP_NUM / 64'd6 + 64'd1, RCP_NUM / 64'd7 + 64'd1,
		RCP_NUM / 64'd8 + 64'd1, RCP_NUM / 64'd9 + 64'd1,
		RCP_NUM / 64'd10 + 64'd1, RCP_NUM / 64'd11 + 64'd1,
		RCP_NUM / 64'd12 + 64'd1, RCP_NUM / 64'd13 + 64'd1,
		RCP_NUM / 64'd14 + 64'd1, RCP_NUM / 64'd15 + 64'd1,
		RCP_NUM / 64'd16 + 64'd1, RCP_NUM / 64'd17 + 64'd1,
		RCP_NUM / 64'd18 + 64'd1, RCP_NUM / 64'd19 + 64'd1,
		RCP_NUM / 64'd20 + 64'd1, RCP_NUM / 64'd21 + 64'd1,
		RCP_NUM / 64'd22 + 64'd1, RCP_NUM / 64'd23 + 64'd1,
		RCP_NUM / 64'd24 + 64'd1, RCP_NUM / 64'd25 + 64'd1,
		RCP_NUM / 64'd26 + 64'd1, RCP_NUM / 64'd27 + 64'd1,
		RCP_NUM / 64'd28 + 64'd1, RCP_NUM / 64'd29 + 64'd1,
		RCP_NUM / 64'd30 + 64'd1, RCP_NUM / 64'd31 + 64'd1,
		RCP_NUM / 64'd32 + 64'd1, RCP_NUM / 64'd33 + 64'd1,
		RCP_NUM / 64'd34 + 64'd1, RCP_NUM / 64'd35 + 64'd1,
		RCP_NUM / 64'd36 + 64'd1, RCP_NUM / 64'd37 + 64'd1,
		RCP_NUM / 64'd38 + 64'd1, RCP_NUM / 64'd39 + 64'd1,
		RCP_NUM / 64'd40 + 64'd1, RCP_NUM / 64'd41 + 64'd1,
		RCP_NUM / 64'd42 + 64'd1, RCP_NUM / 64'd43 + 64'd1,
		RCP_NUM / 64'd44 + 64'd1, RCP_NUM / 64'd45 + 64'd1,
		RCP_NUM / 64'd46 + 64'd1, RCP_NUM / 64'd47 + 64'd1,
		RCP_NUM / 64'd48 + 64'd1, RCP_NUM / 64'd49 + 64'd1,
		RCP_NUM / 64'd50 + 64'd1, RCP_NUM / 64'd51 + 64'd1,
		RCP_NUM / 64'd52 + 64'd1, RCP_NUM / 64'd53 + 64'd1,
		RCP_NUM / 64'd54 + 64'd1, RCP_NUM / 64'd55 + 64'd1,
		RCP_NUM / 64'd56 + 64'd1, RCP_NUM / 64'd57 + 64'd1,
		RCP_NUM / 64'd58 + 64'd1, RCP_NUM / 64'd59 + 64'd1,
		RCP_NUM / 64'd60 + 64'd1, RCP_NUM / 64'd61 + 64'd1,
		RCP_NUM / 64'd62 + 64'd1, RCP_NUM / 64'd63 + 64'd1
	};

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_TERM,
		MUL_XP,
		MUL_DIVH,
		MUL_DIVL
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_INIT,
		OP_ACC,
		OP_XP,
		OP_NUM,
		OP_MAG,
		OP_DIVR,
		OP_PNEXT,
		OP_P1,
		OP_DONE
	} dp_op_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_ALWAYS,
		J_LAST,
		J_KZERO
	} jump_t;

	typedef enum logic [3:0] {
		U_TERM,
		U_ACC,
		U_XP,
		U_NUM,
		U_MAG,
		U_DIVH,
		U_DIVR,
		U_DIVL,
		U_PNEXT,
		U_P1,
		U_DONE
	} upc_t;

	typedef struct packed {
		mul_sel_t mul;
		dp_op_t   op;
	} dp_ctrl_t;

	typedef struct packed {
		dp_ctrl_t dp;
		jump_t    jmp;
		upc_t     target;
	} uword_t;

	// control store: one word per step of a term
	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w = '{dp: '{mul: MUL_NONE, op: OP_NOP}, jmp: J_NEXT, target: U_TERM};
		case (pc)
			U_TERM:  w.dp.mul = MUL_TERM;
			U_ACC: begin
				w.dp = '{mul: MUL_XP, op: OP_ACC};
				w.jmp = J_LAST;
				w.target = U_DONE;
			end
			U_XP: begin
				w.dp.op = OP_XP;
				w.jmp = J_KZERO;
				w.target = U_P1;
			end
			U_NUM:   w.dp.op = OP_NUM;
			U_MAG:   w.dp.op = OP_MAG;
			U_DIVH:  w.dp.mul = MUL_DIVH;
			U_DIVR:  w.dp.op = OP_DIVR;
			U_DIVL:  w.dp.mul = MUL_DIVL;
			U_PNEXT: begin
				w.dp.op = OP_PNEXT;
				w.jmp = J_ALWAYS;
			end
			U_P1: begin
				w.dp.op = OP_P1;
				w.jmp = J_ALWAYS;
			end
			U_DONE:  w.dp.op = OP_DONE;
			default: w.dp.op = OP_DONE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/lse_datapath.sv -----
// arithmetic datapath: shared multiplier, recurrence, reciprocal divide, sum
`default_nettype none

module lse_datapath (
	input  logic                                clk,
	input  lse_pkg::dp_ctrl_t                   ctrl,
	input  logic [lse_pkg::ORD_W-1:0]           k,
	input  logic signed [lse_pkg::X_W-1:0]      x_in,
	input  logic signed [lse_pkg::COEF_W-1:0]   coef,
	output logic signed [lse_pkg::COEF_W-1:0]   series_value,
	output logic                                overflow
);
	import lse_pkg::*;

	localparam logic signed [38:0] SUM_MAX = 39'sh00_7FFF_FFFF;
	localparam logic signed [38:0] SUM_MIN = 39'sh7F_8000_0000;
	localparam logic [37:0]        Q_LIM   = 38'h00_4000_0000;

	logic signed [X_W-1:0]    x_q;
	logic signed [P_W-1:0]    p_prev_q, p_cur_q, xp_q;
	logic signed [38:0]       acc_q;
	logic signed [63:0]       prod_q;
	logic signed [39:0]       num_q;
	logic                     neg_q;
	logic [37:0]              n_q;
	logic [18:0]              qhi_q;
	logic [24:0]              v_q;
	logic signed [COEF_W-1:0] series_value_q;
	logic                     overflow_q;

	logic [6:0]         d;
	logic [5:0]         half_d;
	logic [6:0]         odd_k;
	logic [31:0]        rcp;
	logic signed [32:0] ma, mb;
	logic signed [65:0] mul_p;
	logic [63:0]        prod_mag, sum_t, sum_x;
	logic [31:0]        term_mag;
	logic [38:0]        term_ext;
	logic signed [38:0] term_s;
	logic [30:0]        xp_mag;
	logic signed [P_W-1:0] xp_s;
	logic signed [39:0] num_a, num_b, num_d;
	logic [39:0]        num_mag;
	logic [37:0]        n_d;
	logic [18:0]        qh;
	logic [24:0]        qd, r_full;
	logic [37:0]        qmag;
	logic [30:0]        p_mag;
	logic signed [P_W-1:0] p_new;

	assign d      = {1'b0, k} + 7'd1;
	assign half_d = d[6:1];
	assign odd_k  = {k, 1'b1};
	assign rcp    = RCP_TBL[d[5:0]][31:0];

	always_comb begin
		case (ctrl.mul)
			MUL_TERM: begin
				ma = 33'(coef);
				mb = 33'(p_cur_q);
			end
			MUL_XP: begin
				ma = 33'(x_q);
				mb = 33'(p_cur_q);
			end
			MUL_DIVH: begin
				ma = $signed({14'd0, n_q[37:19]});
				mb = $signed({1'b0, rcp});
			end
			MUL_DIVL: begin
				ma = $signed({8'd0, v_q});
				mb = $signed({1'b0, rcp});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_p = ma * mb;

	// rounding to nearest, ties away from zero, on the magnitude
	assign prod_mag = prod_q[63] ? -prod_q : prod_q;
	assign sum_t    = prod_mag + 64'h2000_0000;
	assign term_mag = sum_t[61:30];
	assign term_ext = {7'd0, term_mag};
	assign term_s   = prod_q[63] ? -$signed(term_ext) : $signed(term_ext);
	assign sum_x    = prod_mag + 64'h8000;
	assign xp_mag   = sum_x[46:16];
	assign xp_s     = prod_q[63] ? -$signed({1'b0, xp_mag}) : $signed({1'b0, xp_mag});

	assign num_a   = 40'(xp_q) * $signed({33'd0, odd_k});
	assign num_b   = 40'(p_prev_q) * $signed({34'd0, k});
	assign num_d   = num_a - num_b;
	assign num_mag = num_q[39] ? -num_q : num_q;
	assign n_d     = num_mag[37:0] + {32'd0, half_d};

	// long division in two 19-bit digits, remainder carried into the low digit
	assign qh     = prod_q[50:32];
	assign qd     = {6'd0, qh} * {18'd0, d};
	assign r_full = {6'd0, n_q[37:19]} - qd;

	assign qmag  = {qhi_q, prod_q[50:32]};
	assign p_mag = (qmag > Q_LIM) ? Q_LIM[30:0] : qmag[30:0];
	assign p_new = neg_q ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

	always_ff @(posedge clk) begin
		if (ctrl.mul != MUL_NONE) begin
			prod_q <= mul_p[63:0];
		end
		case (ctrl.op)
			OP_INIT: begin
				x_q     <= x_in;
				p_cur_q <= ONE_Q30;
				acc_q   <= '0;
			end
			OP_ACC:  acc_q <= acc_q + term_s;
			OP_XP:   xp_q <= xp_s;
			OP_NUM:  num_q <= num_d;
			OP_MAG: begin
				neg_q <= num_q[39];
				n_q   <= n_d;
			end
			OP_DIVR: begin
				qhi_q <= qh;
				v_q   <= {r_full[5:0], n_q[18:0]};
			end
			OP_PNEXT: begin
				p_prev_q <= p_cur_q;
				p_cur_q  <= p_new;
			end
			OP_P1: begin
				p_prev_q <= p_cur_q;
				p_cur_q  <= {x_q, 14'd0};
			end
			OP_DONE: begin
				if (acc_q > SUM_MAX) begin
					series_value_q <= 32'sh7FFF_FFFF;
					overflow_q     <= 1'b1;
				end else if (acc_q < SUM_MIN) begin
					series_value_q <= 32'sh8000_0000;
					overflow_q     <= 1'b1;
				end else begin
					series_value_q <= acc_q[31:0];
					overflow_q     <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign series_value = series_value_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

// ----- design/legendre_series_evaluator.sv -----
// Legendre series evaluator: an item is taken when start is high and busy is low.
// A load item (mode 0) writes one coefficient in its accept cycle and never raises
// busy. An evaluate item (mode 1) holds busy while its microprogram runs; done is
// high for exactly one cycle right after busy falls, with series_value and overflow
// showing the result, and the receiver cannot stall it. The microprogram takes nine
// steps per recurrence term around one shared 33x33 multiplier, which also does the
// term products and the reciprocal division by k+1. A new item may be started in the
// cycle that shows done. The user must write series_order through cfg only while no
// item is open; the block itself does not enforce it.
`default_nettype none

module legendre_series_evaluator #(
	parameter int MAX_TERMS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [lse_pkg::IDX_W-1:0]           coeff_index,
	input  logic signed [lse_pkg::COEF_W-1:0]   coeff_value,
	input  logic signed [lse_pkg::X_W-1:0]      point_x,
	output logic                                done,
	output logic signed [lse_pkg::COEF_W-1:0]   series_value,
	output logic                                overflow,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lse_pkg::ORD_W-1:0]           cfg_data
);
	import lse_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);

	logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];
	logic signed [COEF_W-1:0] coef_rd_q;

	logic             busy_q, done_q;
	upc_t             upc_q, upc_d;
	logic [ORD_W-1:0] k_q, k_d, order_q, order_eff, series_order_q;
	uword_t           uw;
	dp_ctrl_t         dp_ctrl;
	logic             accept, eval_acc, load_acc, take;
	logic signed [X_W-1:0] x_sat;

	assign accept   = start && !busy_q;
	assign eval_acc = accept && mode;
	assign load_acc = accept && !mode;

	assign x_sat = (point_x > X_POS) ? X_POS : ((point_x < X_NEG) ? X_NEG : point_x);
	assign order_eff = (32'(series_order_q) > 32'(MAX_TERMS - 1)) ?
		ORD_W'(MAX_TERMS - 1) : series_order_q;

	assign uw = ucode(upc_q);

	always_comb begin
		if (busy_q) begin
			dp_ctrl = uw.dp;
		end else if (eval_acc) begin
			dp_ctrl = '{mul: MUL_NONE, op: OP_INIT};
		end else begin
			dp_ctrl = '{mul: MUL_NONE, op: OP_NOP};
		end

		case (uw.jmp)
			J_NEXT:   take = 1'b0;
			J_ALWAYS: take = 1'b1;
			J_LAST:   take = (k_q == order_q);
			J_KZERO:  take = (k_q == '0);
			default:  take = 1'b0;
		endcase
		upc_d = take ? uw.target : upc_t'(upc_q + 4'd1);

		k_d = k_q;
		if (eval_acc) begin
			k_d = '0;
		end else if (busy_q && uw.dp.op == OP_P1) begin
			k_d = ORD_W'(1);
		end else if (busy_q && uw.dp.op == OP_PNEXT) begin
			k_d = k_q + ORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			done_q         <= 1'b0;
			upc_q          <= U_TERM;
			k_q            <= '0;
			order_q        <= '0;
			series_order_q <= '0;
		end else begin
			k_q    <= k_d;
			done_q <= busy_q && uw.dp.op == OP_DONE;
			if (busy_q) begin
				upc_q <= upc_d;
				if (uw.dp.op == OP_DONE) begin
					busy_q <= 1'b0;
				end
			end else if (eval_acc) begin
				busy_q  <= 1'b1;
				upc_q   <= U_TERM;
				order_q <= order_eff;
			end
			if (cfg_valid && cfg_ready) begin
				series_order_q <= cfg_data;
			end
		end
	end

	// read address follows the next term index so the word lines up with k_q
	always_ff @(posedge clk) begin
		if (load_acc && 32'(coeff_index) < 32'(MAX_TERMS)) begin
			coef_mem[AW'(coeff_index)] <= coeff_value;
		end
		coef_rd_q <= coef_mem[AW'(k_d)];
	end

	lse_datapath u_dp (
		.clk          (clk),
		.ctrl         (dp_ctrl),
		.k            (k_q),
		.x_in         (x_sat),
		.coef         (coef_rd_q),
		.series_value (series_value),
		.overflow     (overflow)
	);

	assign busy      = busy_q;
	assign done      = done_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- design/lse_chk.sv -----
// port-level checks for the legendre series evaluator, bound to the top level
`default_nettype none
`include "legendre_series_evaluator_assert.svh"

module lse_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        mode,
	input logic        done,
	input logic [31:0] series_value,
	input logic        overflow
);

	`LSE_ASSERT_SAME(a_done_not_busy, done, !busy, "result shown while busy")
	`LSE_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without an open item")
	`LSE_ASSERT_NEXT(a_eval_busy, start && !busy && mode, busy, "evaluate item did not raise busy")
	`LSE_ASSERT_NEXT(a_load_idle, start && !busy && !mode, !busy, "load item raised busy")
	`LSE_ASSERT_SAME(a_ovf_sat, done && overflow,
		series_value == 32'h7FFF_FFFF || series_value == 32'h8000_0000,
		"overflow flagged on an unsaturated value")

endmodule

bind legendre_series_evaluator lse_chk u_lse_chk (.*);

`default_nettype wire
